### design/dim_pkg.sv
// ----------------------------------------------------------------------------
// dim_pkg
// Shared constants, types and the firing-delay function of the phase dimmer.
// ----------------------------------------------------------------------------
package dim_pkg;

  // Channel counts: CHANNELS lanes exist, the first REG_CHANNELS have registers
  localparam int CHANNELS     = 2;
  localparam int REG_CHANNELS = 2;
  localparam int OUT_GATES    = 2;

  // Field widths
  localparam int CNT_W      = 14;
  localparam int PULSE_W    = 6;
  localparam int BRIGHT_W   = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_1 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_2 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE    = 3'd5;

  // Reset values and limits
  localparam logic [CNT_W-1:0]    CNT_MAX       = 14'd16383;
  localparam logic [CNT_W-1:0]    LOCKOUT_RESET = 14'd8500;
  localparam logic [PULSE_W-1:0]  PULSE_RESET   = 6'd10;
  localparam logic [BRIGHT_W-1:0] BRIGHT_MAX    = 7'd100;

  // Delay = 8600 - floor(z*8100/99), z = b-1
  //       = 8600 - 81*z - floor(9*z/11); floor(9z/11) = (z*13410) >> 14 for z <= 99
  localparam logic [CNT_W-1:0] DELAY_LONGEST = 14'd8600;
  localparam logic [CNT_W-1:0] DELAY_STEP    = 14'd81;
  localparam logic [20:0]      DELAY_RECIP   = 21'd13410;

  // Per-channel settings handed to a channel lane
  typedef struct packed {
    logic               active;
    logic [CNT_W-1:0]   delay;
    logic [PULSE_W-1:0] pulse;
  } chan_cfg_t;

  // Firing delay in ticks for a brightness of 1..100; 0 gives the longest delay
  function automatic logic [CNT_W-1:0] delay_of(input logic [BRIGHT_W-1:0] b);
    logic [BRIGHT_W-1:0] z;
    logic [CNT_W-1:0]    coarse;
    logic [20:0]         prod;
    logic [CNT_W-1:0]    fine;
    z      = b - 7'd1;
    coarse = CNT_W'({7'd0, z} * DELAY_STEP);
    prod   = {14'd0, z} * DELAY_RECIP;
    fine   = {7'd0, prod[20:14]};
    if (b == '0) begin
      delay_of = DELAY_LONGEST;
    end else begin
      delay_of = DELAY_LONGEST - coarse - fine;
    end
  endfunction

endpackage

### design/dim_in_if.sv
// ----------------------------------------------------------------------------
// dim_in_if
// Tick channel: one word per microsecond tick with the zero-cross flag.
// ----------------------------------------------------------------------------
interface dim_in_if;
  logic valid;
  logic ready;
  logic zero_cross;

  modport source (output valid, output zero_cross, input ready);
  modport sink   (input valid, input zero_cross, output ready);
endinterface

### design/dim_out_if.sv
// ----------------------------------------------------------------------------
// dim_out_if
// Result channel: gate levels and crossing flag, one word per tick.
// ----------------------------------------------------------------------------
interface dim_out_if;
  logic valid;
  logic ready;
  logic gate_1;
  logic gate_2;
  logic crossing_taken;

  modport source (output valid, output gate_1, output gate_2, output crossing_taken,
                  input ready);
  modport sink   (input valid, input gate_1, input gate_2, input crossing_taken,
                  output ready);
endinterface

### design/two_channel_phase_dimmer.sv
// A tick word's result is offered once it has passed the input register and the
// result register. Throughput: one tick word per cycle while results are taken;
// each holds one word, so one input word is taken while a result waits.
// Reset: synchronous, active low; registers return to their reset values,
// all lanes disarmed and the crossing counter cleared.
// ----------------------------------------------------------------------------
// two_channel_phase_dimmer
// Triac phase-angle dimmer: zero-cross filter feeding per-channel gate timers.
// ----------------------------------------------------------------------------
module two_channel_phase_dimmer
  import dim_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  dim_in_if.sink                in_word,
  dim_out_if.source             out_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  chan_cfg_t            chan_cfg [CHANNELS];
  logic [CNT_W-1:0]     lockout;
  logic                 in_vld_r, in_vld_nxt;
  logic                 zc_r;
  logic                 out_vld_r, out_vld_nxt;
  logic [OUT_GATES-1:0] gate_r;
  logic [OUT_GATES-1:0] gate_vec;
  logic                 taken_r;
  logic [CNT_W-1:0]     tick_r, tick_nxt;
  logic                 adv, fire, taken, in_acc;
  logic [CHANNELS-1:0]  lane_gate;

  dim_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .chan_cfg (chan_cfg),
    .lockout  (lockout)
  );

  // Handshake: the input stage moves when the result register is free
  assign adv           = !out_vld_r || out_word.ready;
  assign fire          = in_vld_r && adv;
  assign in_word.ready = !in_vld_r || adv;
  assign in_acc        = in_word.valid && in_word.ready;

  assign in_vld_nxt  = in_acc ? 1'b1 : (fire ? 1'b0 : in_vld_r);
  assign out_vld_nxt = fire ? 1'b1 : (out_word.ready ? 1'b0 : out_vld_r);

  // Crossing filter: test against the count before this tick
  assign taken    = zc_r && (tick_r > lockout);
  assign tick_nxt = taken ? '0 : ((tick_r != CNT_MAX) ? tick_r + 14'd1 : tick_r);

  // Channel lanes
  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    dim_chan u_chan (
      .clk   (clk),
      .rst_n (rst_n),
      .step  (fire),
      .taken (taken),
      .cfg   (chan_cfg[c]),
      .gate  (lane_gate[c])
    );
  end

  // Map lanes onto the two gate outputs; missing lanes read low
  for (genvar g = 0; g < OUT_GATES; g++) begin : g_gate
    if (g < CHANNELS) begin : g_have
      assign gate_vec[g] = lane_gate[g];
    end else begin : g_none
      assign gate_vec[g] = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      tick_r    <= '0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (fire) begin
        tick_r <= tick_nxt;
      end
    end
  end

  // Payload registers: capture input word, load result word
  always_ff @(posedge clk) begin
    if (in_acc) begin
      zc_r <= in_word.zero_cross;
    end
    if (fire) begin
      gate_r  <= gate_vec;
      taken_r <= taken;
    end
  end

  assign out_word.valid          = out_vld_r;
  assign out_word.gate_1         = gate_r[0];
  assign out_word.gate_2         = gate_r[1];
  assign out_word.crossing_taken = taken_r;

`ifndef ASSERT_OFF
  // An accepted crossing restarts the tick count
  a_tick_clear: assert property (@(posedge clk) disable iff (!rst_n)
    fire && taken |=> tick_r == '0)
    else $error("tick counter not cleared after accepted crossing");

  // The tick count only moves when a tick is processed
  a_tick_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(tick_r))
    else $error("tick counter moved without a processed tick");

  // A blocked input stage keeps its word
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !adv |=> in_vld_r && $stable(zc_r))
    else $error("input stage lost its word while blocked");

  // A processed tick always leaves a result word behind
  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_vld_r)
    else $error("processed tick produced no result word");
`endif

endmodule

### design/dim_cfg.sv
// ----------------------------------------------------------------------------
// dim_cfg
// Configuration registers; the firing delay is looked up on each brightness write.
// ----------------------------------------------------------------------------
module dim_cfg
  import dim_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output chan_cfg_t             chan_cfg [CHANNELS],
  output logic [CNT_W-1:0]      lockout
);

  logic [BRIGHT_W-1:0] bright_r [REG_CHANNELS];
  logic [CNT_W-1:0]    delay_r  [REG_CHANNELS];
  logic                en_r     [REG_CHANNELS];
  logic [CNT_W-1:0]    lockout_r;
  logic [PULSE_W-1:0]  pulse_r;
  logic [BRIGHT_W-1:0] bright_wr;

  // Saturate brightness writes at full scale
  assign bright_wr = (cfg_data[BRIGHT_W-1:0] > BRIGHT_MAX) ? BRIGHT_MAX
                                                          : cfg_data[BRIGHT_W-1:0];

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < REG_CHANNELS; c++) begin
        bright_r[c] <= '0;
        delay_r[c]  <= DELAY_LONGEST;
        en_r[c]     <= 1'b0;
      end
      lockout_r <= LOCKOUT_RESET;
      pulse_r   <= PULSE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_BRIGHT_1: begin
          bright_r[0] <= bright_wr;
          delay_r[0]  <= delay_of(bright_wr);
        end
        REG_BRIGHT_2: begin
          bright_r[1] <= bright_wr;
          delay_r[1]  <= delay_of(bright_wr);
        end
        REG_ENABLE_1: en_r[0]   <= cfg_data[0];
        REG_ENABLE_2: en_r[1]   <= cfg_data[0];
        REG_LOCKOUT:  lockout_r <= cfg_data[CNT_W-1:0];
        REG_PULSE:    pulse_r   <= cfg_data[PULSE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Hand each lane its settings; lanes without registers stay off
  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    if (c < REG_CHANNELS) begin : g_reg
      assign chan_cfg[c].active = en_r[c] && (bright_r[c] != '0);
      assign chan_cfg[c].delay  = delay_r[c];
      assign chan_cfg[c].pulse  = pulse_r;
    end else begin : g_off
      assign chan_cfg[c] = '0;
    end
  end

  assign lockout = lockout_r;

endmodule

### design/dim_chan.sv
// ----------------------------------------------------------------------------
// dim_chan
// One dimmer lane: phase counter, arm flag and gate pulse counter.
// ----------------------------------------------------------------------------
module dim_chan
  import dim_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  logic      taken,
  input  chan_cfg_t cfg,
  output logic      gate
);

  logic [CNT_W-1:0]   phase_r, phase_nxt, phase_inc;
  logic               armed_r, armed_nxt;
  logic [PULSE_W-1:0] pulse_r, pulse_nxt, pulse_cur;

  assign phase_inc = (phase_r != CNT_MAX) ? phase_r + 14'd1 : phase_r;

  // Work out this tick's lane update
  always_comb begin
    phase_nxt = phase_r;
    armed_nxt = armed_r;
    pulse_cur = pulse_r;
    gate      = 1'b0;
    pulse_nxt = pulse_r;
    if (!cfg.active) begin
      armed_nxt = 1'b0;
      pulse_nxt = '0;
    end else begin
      if (taken) begin
        phase_nxt = '0;
        armed_nxt = 1'b1;
      end else if (armed_r) begin
        phase_nxt = phase_inc;
        if (phase_inc >= cfg.delay) begin
          armed_nxt = 1'b0;
          pulse_cur = cfg.pulse;
        end
      end
      gate      = (pulse_cur != '0);
      pulse_nxt = gate ? pulse_cur - 6'd1 : pulse_cur;
    end
  end

  // Advance the lane once per processed tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      armed_r <= 1'b0;
      pulse_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      armed_r <= armed_nxt;
      pulse_r <= pulse_nxt;
    end
  end

endmodule
